// ----- sv/ssc_pkg.sv -----
// Shared types and constants of the sensor smoothing and change reporter.
// No dependencies; imported by the top level, the filter, the checker and the testbench.
package ssc_pkg;

    localparam int unsigned AXES       = 3;
    localparam int unsigned VAL_W      = 16;
    localparam int unsigned CFG_W      = 8;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CFG_W-1:0]        t_cfg;

    // Register indexes (word address = paddr[3:2]).
    typedef enum logic [1:0] {
        REG_REPORT_PERIOD  = 2'd0,
        REG_ROTATION_PHASE = 2'd1,
        REG_GYRO_PERIOD    = 2'd2,
        REG_GYRO_PHASE     = 2'd3
    } t_reg_idx;

    localparam t_cfg RST_REPORT_PERIOD  = 8'd20;
    localparam t_cfg RST_ROTATION_PHASE = 8'd10;
    localparam t_cfg RST_GYRO_PERIOD    = 8'd3;
    localparam t_cfg RST_GYRO_PHASE     = 8'd1;

    localparam logic KIND_ACCEL    = 1'b0;
    localparam logic KIND_ROTATION = 1'b1;

endpackage

// ----- sv/sensor_smoothing_change_reporter_unit.sv -----
// A request is registered in the input register on acceptance, and its report, if
// any, is registered in the result register when the request moves on.
// Throughput: one request per cycle, set by the single compute stage between the
// input register and the result register; a held result stalls the input only
// once the input register is also full. Reset (synchronous, active low) clears
// the phase counters, the filter and last-sent triples and restores the registers.
module sensor_smoothing_change_reporter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tick request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ssc_pkg::t_val                      i_accel_x,
    input  ssc_pkg::t_val                      i_accel_y,
    input  ssc_pkg::t_val                      i_accel_z,
    input  ssc_pkg::t_val                      i_rate_x,
    input  ssc_pkg::t_val                      i_rate_y,
    input  ssc_pkg::t_val                      i_rate_z,
    // report channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_report_kind,
    output ssc_pkg::t_val                      o_value_x,
    output ssc_pkg::t_val                      o_value_y,
    output ssc_pkg::t_val                      o_value_z,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ssc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ssc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import ssc_pkg::*;

    // Configuration registers
    t_cfg r_report_period;
    t_cfg r_rotation_phase;
    t_cfg r_gyro_period;
    t_cfg r_gyro_phase;

    // Block state
    t_cfg r_report_count;
    t_cfg r_gyro_count;
    t_val r_last_accel [AXES];
    t_val r_filt       [AXES];
    t_val r_last_rate  [AXES];

    // Input register
    logic r_in_valid;
    t_val r_accel [AXES];
    t_val r_rate  [AXES];

    // Result register
    logic r_out_valid;
    logic r_kind;
    t_val r_val [AXES];

    // Compute stage
    logic         out_free;
    logic         in_ready;
    logic         fire;
    logic [CFG_W:0] rc_inc;
    logic [CFG_W:0] gc_inc;
    t_cfg         n_report_count;
    t_cfg         n_gyro_count;
    logic         accel_diff;
    logic         rate_diff;
    logic         accel_due;
    logic         filt_due;
    logic         rot_due;
    t_val         filt_upd [AXES];
    t_val         n_filt   [AXES];
    logic         cfg_wr;
    t_reg_idx     cfg_idx;

    // Handshake: the result register frees when empty or being taken; the input
    // register takes a new request whenever it can hand its own one forward.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_ready   = !r_in_valid || out_free;
    assign o_in_stall = !in_ready;
    assign fire       = r_in_valid && out_free;

    // Phase counters wrap once count + 1 reaches the period (period 0 acts as 1).
    assign rc_inc         = {1'b0, r_report_count} + (CFG_W+1)'(1);
    assign gc_inc         = {1'b0, r_gyro_count} + (CFG_W+1)'(1);
    assign n_report_count = (rc_inc >= {1'b0, r_report_period}) ? '0 : rc_inc[CFG_W-1:0];
    assign n_gyro_count   = (gc_inc >= {1'b0, r_gyro_period}) ? '0 : gc_inc[CFG_W-1:0];

    // Filter per axis; the updated value is seen by this tick's rotation check.
    for (genvar a = 0; a < AXES; a++) begin : g_axis
        ssc_ema u_ema (
            .i_filt (r_filt[a]),
            .i_rate (r_rate[a]),
            .o_filt (filt_upd[a])
        );
        assign n_filt[a] = filt_due ? filt_upd[a] : r_filt[a];
    end

    assign filt_due = (n_gyro_count == r_gyro_phase);

    always_comb begin
        accel_diff = 1'b0;
        rate_diff  = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            accel_diff = accel_diff || (r_accel[a] != r_last_accel[a]);
            rate_diff  = rate_diff  || (n_filt[a] != r_last_rate[a]);
        end
    end

    // Acceleration wins a shared phase; a skipped rotation report keeps last_rate.
    assign accel_due = (n_report_count == '0) && accel_diff;
    assign rot_due   = !accel_due && (n_report_count == r_rotation_phase) && rate_diff;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (in_ready && i_in_valid) begin
            r_accel[0] <= i_accel_x;
            r_accel[1] <= i_accel_y;
            r_accel[2] <= i_accel_z;
            r_rate[0]  <= i_rate_x;
            r_rate[1]  <= i_rate_y;
            r_rate[2]  <= i_rate_z;
        end
    end

    // Block state: advance only when the registered request moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_count <= '0;
            r_gyro_count   <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_last_accel[a] <= '0;
                r_filt[a]       <= '0;
                r_last_rate[a]  <= '0;
            end
        end else if (fire) begin
            r_report_count <= n_report_count;
            r_gyro_count   <= n_gyro_count;
            for (int a = 0; a < AXES; a++) begin
                r_filt[a] <= n_filt[a];
                if (accel_due) begin
                    r_last_accel[a] <= r_accel[a];
                end
                if (rot_due) begin
                    r_last_rate[a] <= n_filt[a];
                end
            end
        end
    end

    // Result register: hold while stalled, load the report of the firing request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && (accel_due || rot_due);
        end
        if (fire) begin
            r_kind <= accel_due ? KIND_ACCEL : KIND_ROTATION;
            for (int a = 0; a < AXES; a++) begin
                r_val[a] <= accel_due ? r_accel[a] : n_filt[a];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_report_kind = r_kind;
    assign o_value_x     = r_val[0];
    assign o_value_y     = r_val[1];
    assign o_value_z     = r_val[2];

    // Configuration port: zero-wait writes in the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_period  <= RST_REPORT_PERIOD;
            r_rotation_phase <= RST_ROTATION_PHASE;
            r_gyro_period    <= RST_GYRO_PERIOD;
            r_gyro_phase     <= RST_GYRO_PHASE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_REPORT_PERIOD:  r_report_period  <= pwdata[CFG_W-1:0];
                REG_ROTATION_PHASE: r_rotation_phase <= pwdata[CFG_W-1:0];
                REG_GYRO_PERIOD:    r_gyro_period    <= pwdata[CFG_W-1:0];
                REG_GYRO_PHASE:     r_gyro_phase     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_REPORT_PERIOD:  prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_report_period};
            REG_ROTATION_PHASE: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_rotation_phase};
            REG_GYRO_PERIOD:    prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_gyro_period};
            REG_GYRO_PHASE:     prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_gyro_phase};
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- sv/ssc_ema.sv -----
// One axis of the quarter-weight smoothing filter: f' = trunc(3f/4) + trunc(g/4).
// Depends on ssc_pkg.
module ssc_ema (
    input  ssc_pkg::t_val i_filt,
    input  ssc_pkg::t_val i_rate,
    output ssc_pkg::t_val o_filt
);
    import ssc_pkg::*;

    logic signed [VAL_W+1:0] f3;
    logic signed [VAL_W+1:0] f3_adj;
    logic signed [VAL_W+1:0] q_filt;
    logic signed [VAL_W:0]   g_adj;
    logic signed [VAL_W:0]   q_rate;
    logic signed [VAL_W+1:0] sum;

    // Bias negative values by 3 before the shift so it truncates toward zero.
    assign f3     = {{2{i_filt[VAL_W-1]}}, i_filt} + {i_filt[VAL_W-1], i_filt, 1'b0};
    assign f3_adj = f3 + (f3[VAL_W+1] ? (VAL_W+2)'(3) : (VAL_W+2)'(0));
    assign q_filt = f3_adj >>> 2;
    assign g_adj  = {i_rate[VAL_W-1], i_rate}
                  + (i_rate[VAL_W-1] ? (VAL_W+1)'(3) : (VAL_W+1)'(0));
    assign q_rate = g_adj >>> 2;
    assign sum    = q_filt + {q_rate[VAL_W], q_rate};
    assign o_filt = sum[VAL_W-1:0];

endmodule

// ----- sv/ssc_checker.sv -----
// Port-level checks of the sensor smoothing and change reporter, bound to the top.
// Depends on ssc_pkg and sensor_smoothing_change_reporter_unit.
module ssc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic          o_report_kind,
    input ssc_pkg::t_val o_value_x,
    input ssc_pkg::t_val o_value_y,
    input ssc_pkg::t_val o_value_z,
    input logic          pready
);
    import ssc_pkg::*;

    logic out_take;
    logic r_chk_armed;
    t_val r_prev_accel [AXES];
    t_val r_prev_rate  [AXES];

    assign out_take = o_out_valid && !i_out_stall;

    // Track the last report of each kind that went out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_armed <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_prev_accel[a] <= '0;
                r_prev_rate[a]  <= '0;
            end
        end else begin
            r_chk_armed <= 1'b1;
            if (out_take && o_report_kind == KIND_ACCEL) begin
                r_prev_accel[0] <= o_value_x;
                r_prev_accel[1] <= o_value_y;
                r_prev_accel[2] <= o_value_z;
            end
            if (out_take && o_report_kind == KIND_ROTATION) begin
                r_prev_rate[0] <= o_value_x;
                r_prev_rate[1] <= o_value_y;
                r_prev_rate[2] <= o_value_z;
            end
        end
    end

    // A held report keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_report_kind) && $stable(o_value_x)
            && $stable(o_value_y) && $stable(o_value_z))
        else $error("report changed while stalled");

    // Each report must differ from the previous report of its kind.
    a_accel_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_armed && out_take && o_report_kind == KIND_ACCEL |->
            o_value_x != r_prev_accel[0] || o_value_y != r_prev_accel[1]
            || o_value_z != r_prev_accel[2])
        else $error("acceleration report repeats the last one");

    a_rate_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_armed && out_take && o_report_kind == KIND_ROTATION |->
            o_value_x != r_prev_rate[0] || o_value_y != r_prev_rate[1]
            || o_value_z != r_prev_rate[2])
        else $error("rotation report repeats the last one");

    // The input side backs up only behind a held report.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall && pready)
        else $error("input stalled without a held report");

endmodule

bind sensor_smoothing_change_reporter_unit ssc_checker u_ssc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_report_kind (o_report_kind),
    .o_value_x     (o_value_x),
    .o_value_y     (o_value_y),
    .o_value_z     (o_value_z),
    .pready        (pready)
);

// ----- sim/sensor_smoothing_change_reporter_unit_test.sv -----
// Self-checking testbench for sensor_smoothing_change_reporter_unit.
// Depends on ssc_pkg and the unit itself; tracks every report against a built-in
// model of the phase counters, the rate filter and the change detection.
module sensor_smoothing_change_reporter_unit_test;
    import ssc_pkg::*;

    // One triple per sensor; element 0 is the x axis, each element stays signed.
    typedef t_val [AXES-1:0] t_triple;

    typedef struct {
        t_triple     accel;
        t_triple     rate;
        int unsigned gap;       // idle cycles before this request is offered
    } t_tick;

    typedef struct {
        logic    kind;
        t_triple value;
    } t_report;

    localparam t_val VAL_MAX      = 16'sh7FFF;
    localparam t_val VAL_MIN      = 16'sh8000;
    localparam int   DRAIN_CYCLES = 6;      // two-stage pipe plus margin
    localparam int   HOLD_CYCLES  = 200;    // long receiver hold-off
    localparam int   MAX_GAP      = 13;

    // ------------------------------------------------------------------
    // Clock and DUT ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_val i_accel_x = '0;
    t_val i_accel_y = '0;
    t_val i_accel_z = '0;
    t_val i_rate_x = '0;
    t_val i_rate_y = '0;
    t_val i_rate_z = '0;

    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_report_kind;
    t_val o_value_x;
    t_val o_value_y;
    t_val o_value_z;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    sensor_smoothing_change_reporter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_accel_z     (i_accel_z),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_rate_z      (i_rate_z),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_report_kind (o_report_kind),
        .o_value_x     (o_value_x),
        .o_value_y     (o_value_y),
        .o_value_z     (o_value_z),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_tick   tick_queue[$];        // requests waiting for the driver
    t_report pending_reports[$];   // predicted reports, oldest first

    logic tick_fire   = 1'b0;      // request handshake seen at the last rising edge
    logic report_fire = 1'b0;      // report handshake seen at the last rising edge

    bit sender_calm   = 1'b0;      // offer back to back
    bit receiver_calm = 1'b0;      // take reports without stalling
    bit hold_armed    = 1'b0;      // ask the receiver for a long hold-off

    int errors           = 0;
    int ticks_taken      = 0;
    int reports_checked  = 0;
    int settings_applied = 0;

    // Register mirror, starting from the reset values.
    t_cfg cfg_report_period  = RST_REPORT_PERIOD;
    t_cfg cfg_rotation_phase = RST_ROTATION_PHASE;
    t_cfg cfg_gyro_period    = RST_GYRO_PERIOD;
    t_cfg cfg_gyro_phase     = RST_GYRO_PHASE;

    // Predicted internal state of the unit; all of it clears on reset.
    t_cfg    report_phase_cnt = '0;
    t_cfg    gyro_phase_cnt   = '0;
    t_triple sent_accel       = '0;
    t_triple smoothed_rate    = '0;
    t_triple sent_rate        = '0;

    // Generator memory, so that runs of repeated triples occur.
    t_triple gen_accel = '0;
    t_triple gen_rate  = '0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // Wrap to zero once count + 1 reaches the period; a period of zero or one
    // pins the counter at zero, and a counter above a lowered period drops to zero.
    function automatic t_cfg next_phase(input t_cfg cnt, input t_cfg period);
        logic [CFG_W:0] n;
        n = {1'b0, cnt} + (CFG_W+1)'(1);
        return (n >= {1'b0, period}) ? '0 : n[CFG_W-1:0];
    endfunction

    // Advance the model by one request; return 1 with the report if one is due.
    function automatic bit smooth_and_report(input t_tick t, output t_report rep);
        bit sent;
        int f;
        int g;
        sent = 1'b0;
        rep.kind  = KIND_ACCEL;
        rep.value = '0;
        report_phase_cnt = next_phase(report_phase_cnt, cfg_report_period);
        gyro_phase_cnt   = next_phase(gyro_phase_cnt, cfg_gyro_period);

        if (report_phase_cnt == '0 && t.accel != sent_accel) begin
            rep.kind   = KIND_ACCEL;
            rep.value  = t.accel;
            sent_accel = t.accel;
            sent       = 1'b1;
        end

        // Quarter-weight smoothing, both terms truncated toward zero.
        if (gyro_phase_cnt == cfg_gyro_phase) begin
            for (int i = 0; i < AXES; i++) begin
                f = smoothed_rate[i];
                g = t.rate[i];
                smoothed_rate[i] = t_val'((f * 3) / 4 + g / 4);
            end
        end

        // Rotation loses to acceleration on a shared tick and then keeps its
        // last-sent triple untouched.
        if (!sent && report_phase_cnt == cfg_rotation_phase &&
                smoothed_rate != sent_rate) begin
            rep.kind  = KIND_ROTATION;
            rep.value = smoothed_rate;
            sent_rate = smoothed_rate;
            sent      = 1'b1;
        end
        return sent;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [VAL_W-1:0] want,
                                        input logic signed [VAL_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, predict on every
    // accepted request and compare every accepted report with the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tick   seen;
        t_report predicted;
        t_report want;
        tick_fire   = i_rst_n && i_in_valid && !o_in_stall;
        report_fire = i_rst_n && o_out_valid && !i_out_stall;

        if (tick_fire) begin
            seen.accel = {i_accel_z, i_accel_y, i_accel_x};
            seen.rate  = {i_rate_z, i_rate_y, i_rate_x};
            seen.gap   = 0;
            ticks_taken++;
            if (smooth_and_report(seen, predicted))
                pending_reports.push_back(predicted);
        end

        if (report_fire) begin
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report, expected none, actual kind %0d (%0d %0d %0d)",
                         $time, o_report_kind, o_value_x, o_value_y, o_value_z);
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                check_field("report_kind", t_val'(want.kind), t_val'(o_report_kind));
                check_field("value_x", want.value[0], o_value_x);
                check_field("value_y", want.value[1], o_value_y);
                check_field("value_z", want.value[2], o_value_z);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: at the falling edge drop a request that was just taken, sit out
    // the next request's gap, then offer it. A request that is still stalled
    // holds its payload untouched.
    // ------------------------------------------------------------------
    int unsigned gap_left   = 0;
    bit          gap_loaded = 1'b0;

    always @(negedge i_clk) begin
        t_tick nxt;
        if (!(i_in_valid && !tick_fire)) begin
            if (tick_queue.size() != 0 && !gap_loaded) begin
                gap_left   = tick_queue[0].gap;
                gap_loaded = 1'b1;
            end
            if (tick_queue.size() != 0 && gap_left == 0) begin
                nxt        = tick_queue.pop_front();
                gap_loaded = 1'b0;
                i_accel_x  <= nxt.accel[0];
                i_accel_y  <= nxt.accel[1];
                i_accel_z  <= nxt.accel[2];
                i_rate_x   <= nxt.rate[0];
                i_rate_y   <= nxt.rate[1];
                i_rate_z   <= nxt.rate[2];
                i_in_valid <= 1'b1;
            end else begin
                if (gap_left > 0)
                    gap_left--;
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: draw a stall length after every taken report, and on request
    // hold off for a long stretch so that the unit backs up into its input.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;

    always @(negedge i_clk) begin
        if (report_fire)
            stall_left = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (hold_armed) begin
            hold_left  = HOLD_CYCLES;
            hold_armed = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Favor the extremes and small values around zero, where truncation shows.
    function automatic t_val rand_sample();
        case ($urandom_range(0, 7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return t_val'(-1);
            4: return t_val'(int'($urandom_range(0, 16)) - 8);
            default: return t_val'($urandom);
        endcase
    endfunction

    function automatic t_triple rand_triple();
        t_triple tr;
        for (int i = 0; i < AXES; i++)
            tr[i] = rand_sample();
        return tr;
    endfunction

    task automatic push_tick(input t_val ax, input t_val ay, input t_val az,
                             input t_val rx, input t_val ry, input t_val rz);
        t_tick t;
        t.accel = {az, ay, ax};
        t.rate  = {rz, ry, rx};
        t.gap   = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        tick_queue.push_back(t);
    endtask

    // Repeat triples often so that unchanged data suppresses reports and the
    // rotation report gets its turn on shared ticks.
    task automatic queue_random(input int n);
        t_tick t;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 1) == 0)
                gen_accel = rand_triple();
            if ($urandom_range(0, 2) != 0)
                gen_rate = rand_triple();
            t.accel = gen_accel;
            t.rate  = gen_rate;
            t.gap   = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
            tick_queue.push_back(t);
        end
    endtask

    // Wait until every request is taken and every report checked, then let the
    // pipe run dry, since a request without a report leaves nothing to wait on.
    task automatic settle();
        while (tick_queue.size() != 0 || i_in_valid || pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register with a setup and an access cycle, read it back the
    // same way, then update the mirror.
    task automatic cfg_write(input t_reg_idx idx, input t_cfg val);
        logic [APB_DATA_W-1:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DATA_W'(val)) begin
            errors++;
            $display("%0t: register %s readback mismatch, expected %0d, actual %0d",
                     $time, idx.name(), val, readback);
        end
        case (idx)
            REG_REPORT_PERIOD:  cfg_report_period  = val;
            REG_ROTATION_PHASE: cfg_rotation_phase = val;
            REG_GYRO_PERIOD:    cfg_gyro_period    = val;
            REG_GYRO_PHASE:     cfg_gyro_phase     = val;
            default: ;
        endcase
    endtask

    // Drain, rewrite all four registers and pick the idling style of the phase.
    task automatic apply_setting(input t_cfg rep_period, input t_cfg rot_phase,
                                 input t_cfg gyr_period, input t_cfg gyr_phase);
        settle();
        cfg_write(REG_REPORT_PERIOD, rep_period);
        cfg_write(REG_ROTATION_PHASE, rot_phase);
        cfg_write(REG_GYRO_PERIOD, gyr_period);
        cfg_write(REG_GYRO_PHASE, gyr_phase);
        settings_applied++;
        sender_calm   = ($urandom_range(0, 2) == 0);
        receiver_calm = ($urandom_range(0, 2) == 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg rp;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the registers, no write yet.
        queue_random(120);

        // Every tick reports, filters and shares the report slot: walk the
        // field extremes, bit patterns and truncation of negative rates.
        apply_setting(8'd1, 8'd0, 8'd1, 8'd0);
        push_tick('0, '0, '0, '0, '0, '0);
        push_tick(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        repeat (3) push_tick(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        push_tick(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
        repeat (4) push_tick(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
        push_tick(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        push_tick(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        repeat (2) push_tick(16'shAAAA, 16'sh5555, 16'shAAAA, -16'sd1, -16'sd2, -16'sd3);
        repeat (3) push_tick(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sd3, -16'sd5, 16'sd7);
        repeat (2) push_tick('0, '0, '0, '0, '0, '0);

        // Widest periods with the latest phases.
        apply_setting(8'd255, 8'd254, 8'd255, 8'd254);
        queue_random(260);

        // Lower the periods below the running counters.
        apply_setting(8'd4, 8'd2, 8'd3, 8'd2);
        queue_random(60);

        // Period of zero behaves as a period of one.
        apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
        queue_random(40);

        // Phases at or beyond their periods never fire.
        apply_setting(8'd3, 8'd5, 8'd2, 8'd7);
        queue_random(40);

        // Report every tick while the receiver holds off: fill the pipe and
        // stall the request side with back-to-back offers.
        apply_setting(8'd1, 8'd0, 8'd1, 8'd0);
        sender_calm = 1'b1;
        hold_armed  = 1'b1;
        queue_random(60);

        // Random settings, mostly short periods so that reports come often.
        repeat (5) begin
            rp = ($urandom_range(0, 4) == 0) ? t_cfg'($urandom_range(0, 255))
                                             : t_cfg'($urandom_range(0, 12));
            apply_setting(rp, t_cfg'($urandom_range(0, rp + 1)),
                          t_cfg'($urandom_range(0, 8)), t_cfg'($urandom_range(0, 8)));
            queue_random(20);
        end

        settle();
        $display("%0d ticks taken over %0d register settings, %0d reports compared",
                 ticks_taken, settings_applied, reports_checked);
        $display("settings included zero, unreachable, lowered and widest periods");
        $display("and one long receiver hold-off that backed up the request side");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5000000;
        $display("%0t: timeout with %0d reports outstanding", $time, pending_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ssc_pkg.sv
sv/ssc_ema.sv
sv/sensor_smoothing_change_reporter_unit.sv
sv/ssc_checker.sv
sim/sensor_smoothing_change_reporter_unit_test.sv
